/* rtl/ack_retry_tracker_macros.svh */
// Assertion macros for the acknowledgement retry tracker.
// Define NO_ASSERTIONS to compile them away.
`ifndef ACK_RETRY_TRACKER_MACROS_SVH
`define ACK_RETRY_TRACKER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ART_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ART_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ART_ASSERT(lbl, prop, msg)
`define ART_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

/* rtl/art_pkg.sv */
// Shared types, codes and helpers of the acknowledgement retry tracker.
// Used by the slot cells, the slot ring and the top level.
package art_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int OUT_LIMIT   = 16;

    localparam logic [1:0] MODE_POST   = 2'd0;
    localparam logic [1:0] MODE_ACK    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_TICK   = 2'd3;

    localparam logic [2:0] KIND_SEND      = 3'd0;
    localparam logic [2:0] KIND_DELIVERED = 3'd1;
    localparam logic [2:0] KIND_FAILED    = 3'd2;
    localparam logic [2:0] KIND_NOACTION  = 3'd3;
    localparam logic [2:0] KIND_FULL      = 3'd4;

    localparam logic [1:0] REG_MAX_RETRY      = 2'd0;
    localparam logic [1:0] REG_RETRY_INTERVAL = 2'd1;

    localparam logic [7:0]  MAX_RETRY_RST      = 8'd3;
    localparam logic [15:0] RETRY_INTERVAL_RST = 16'd10;

    typedef struct packed {
        logic [63:0] msg_id;
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  count;
        logic [31:0] stamp;
    } slot_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] msg_id;
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  count;
        logic        last;
    } res_t;

    function automatic logic [7:0] sat_inc(input logic [7:0] c);
        sat_inc = (c == 8'hFF) ? 8'hFF : c + 8'd1;
    endfunction

endpackage

/* rtl/art_in_if.sv */
// Input channel of the tracker: valid/ready handshake with one request word.
// Depends on nothing.
interface art_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] msg_id;
    logic [31:0] client_addr;
    logic [15:0] client_port;
    logic [31:0] now;

    modport source (output valid, mode, msg_id, client_addr, client_port, now,
                    input ready);
    modport sink   (input valid, mode, msg_id, client_addr, client_port, now,
                    output ready);
endinterface

/* rtl/art_out_if.sv */
// Result channel of the tracker: valid/ready handshake with one result word.
// Depends on nothing.
interface art_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [63:0] out_msg_id;
    logic [31:0] out_addr;
    logic [15:0] out_port;
    logic [7:0]  out_count;
    logic        last_result;

    modport source (output valid, kind, out_msg_id, out_addr, out_port, out_count,
                    last_result, input ready);
    modport sink   (input valid, kind, out_msg_id, out_addr, out_port, out_count,
                    last_result, output ready);
endinterface

/* rtl/art_cell.sv */
// One slot of the rotating table: a valid flag and the slot contents.
// Depends on art_pkg.
module art_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          shift,
    input  logic          valid_in,
    input  art_pkg::slot_t slot_in,
    output logic          valid_reg,
    output art_pkg::slot_t slot_reg
);
    import art_pkg::*;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (shift)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            slot_reg <= slot_in;
        end
    end

endmodule

/* rtl/art_ring.sv */
// Ring of slot cells; each shift moves every slot one cell toward the head.
// Depends on art_pkg and art_cell.
module art_ring #(
    parameter int ENTRIES = art_pkg::ENTRIES_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           shift,
    input  logic           feed_valid,
    input  art_pkg::slot_t feed_slot,
    output logic           head_valid,
    output art_pkg::slot_t head_slot
);
    import art_pkg::*;

    logic  cv [ENTRIES];
    slot_t cs [ENTRIES];

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++)
        begin : g_cell
            if (g == ENTRIES - 1)
            begin : g_tail
                art_cell u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .valid_in(feed_valid), .slot_in(feed_slot),
                    .valid_reg(cv[g]), .slot_reg(cs[g])
                );
            end
            else
            begin : g_body
                art_cell u_cell (
                    .clk(clk), .rst_n(rst_n), .shift(shift),
                    .valid_in(cv[g+1]), .slot_in(cs[g+1]),
                    .valid_reg(cv[g]), .slot_reg(cs[g])
                );
            end
        end
    endgenerate

    assign head_valid = cv[0];
    assign head_slot  = cs[0];

endmodule

/* rtl/ack_retry_tracker.sv */
// Acknowledgement retry tracker: table of pending messages in a ring of cells.
// Depends on art_pkg, art_in_if, art_out_if, art_ring and the macro header.
//
// Usage: requests enter on in_ch (post, ack, remove, tick); results leave on
// out_ch, the last result of a request marked by last_result. Registers
// max_retry (index 0) and retry_interval (index 1) are written on the cfg port;
// the user must write them only while the block is idle; it does not enforce this.
// The slots circulate through a ring of ENTRIES cells, one slot reaching the
// head cell per cycle unless the ring is stalled, so a full turn visits slots
// in order. Post and ack take two turns (find, then update); a post to a full
// table and an ack without a match skip the update turn. Remove and tick take
// one turn plus a flush.
// One request is worked on at a time; in_ch.ready is high only while idle.
// Results pass through a one-word hold stage and an output register; when the
// receiver stalls with both full, the ring stops rotating until it drains.
// Reset empties the table and loads max_retry 3 and retry_interval 10.
`include "ack_retry_tracker_macros.svh"
module ack_retry_tracker #(
    parameter int ENTRIES = art_pkg::ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    art_in_if.sink      in_ch,
    art_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_data
);
    import art_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_APPLY, ST_FLUSH} state_t;

    state_t      state_reg;
    logic [IW-1:0] cnt_reg;
    logic [4:0]  n_reg;
    logic [1:0]  mode_reg;
    logic [63:0] id_reg;
    logic [31:0] addr_reg;
    logic [15:0] port_reg;
    logic [31:0] now_reg;
    logic [7:0]  max_retry_reg;
    logic [15:0] interval_reg;
    logic        m_found_reg, f_found_reg;
    logic [IW-1:0] m_idx_reg, f_idx_reg, tgt_reg;
    logic [7:0]  m_cnt_reg;
    logic        pend_valid_reg;
    res_t        pend_reg;
    logic        out_valid_reg;
    res_t        out_reg;

    logic        head_valid;
    slot_t       head_slot;
    logic        feed_valid;
    slot_t       feed_slot;
    logic        shift;
    logic        new_res, stall, out_free, key_hit, last_step;
    res_t        res;
    logic        m_found_c, f_found_c;
    logic [IW-1:0] m_idx_c, f_idx_c;
    logic [7:0]  m_cnt_c;
    logic [32:0] due;

    art_ring #(.ENTRIES(ENTRIES)) u_ring (
        .clk(clk), .rst_n(rst_n), .shift(shift),
        .feed_valid(feed_valid), .feed_slot(feed_slot),
        .head_valid(head_valid), .head_slot(head_slot)
    );

    assign out_free  = !out_valid_reg || out_ch.ready;
    assign key_hit   = head_valid && head_slot.msg_id == id_reg
                       && head_slot.addr == addr_reg && head_slot.port == port_reg;
    assign due       = {1'b0, head_slot.stamp} + {17'd0, interval_reg};
    assign last_step = cnt_reg == LAST_IDX;

    always_comb
    begin
        feed_valid = head_valid;
        feed_slot  = head_slot;
        new_res    = 1'b0;
        res        = '{kind: KIND_FAILED, msg_id: head_slot.msg_id,
                       addr: head_slot.addr, port: head_slot.port,
                       count: head_slot.count, last: 1'b0};
        m_found_c  = m_found_reg;
        m_idx_c    = m_idx_reg;
        m_cnt_c    = m_cnt_reg;
        f_found_c  = f_found_reg;
        f_idx_c    = f_idx_reg;
        if (state_reg == ST_SCAN)
        begin
            case (mode_reg)
                MODE_POST, MODE_ACK:
                begin
                    if (key_hit && !m_found_reg)
                    begin
                        m_found_c = 1'b1;
                        m_idx_c   = cnt_reg;
                        m_cnt_c   = head_slot.count;
                    end
                    if (!head_valid && !f_found_reg)
                    begin
                        f_found_c = 1'b1;
                        f_idx_c   = cnt_reg;
                    end
                end
                MODE_REMOVE:
                begin
                    if (head_valid && head_slot.msg_id == id_reg && n_reg < 5'(OUT_LIMIT))
                    begin
                        feed_valid = 1'b0;
                        new_res    = 1'b1;
                    end
                end
                default:
                begin
                    if (head_valid && n_reg < 5'(OUT_LIMIT))
                    begin
                        if (head_slot.count >= max_retry_reg)
                        begin
                            feed_valid = 1'b0;
                            new_res    = 1'b1;
                        end
                        else if (due < {1'b0, now_reg})
                        begin
                            feed_slot.stamp = now_reg;
                            feed_slot.count = sat_inc(head_slot.count);
                            new_res   = 1'b1;
                            res.kind  = KIND_SEND;
                            res.count = feed_slot.count;
                        end
                    end
                end
            endcase
        end
        else if (state_reg == ST_APPLY && cnt_reg == tgt_reg)
        begin
            if (mode_reg == MODE_ACK)
            begin
                feed_valid = 1'b0;
            end
            else if (m_found_reg)
            begin
                feed_slot.count = sat_inc(head_slot.count);
                feed_slot.stamp = now_reg;
            end
            else
            begin
                feed_valid = 1'b1;
                feed_slot  = '{msg_id: id_reg, addr: addr_reg, port: port_reg,
                               count: 8'd1, stamp: now_reg};
            end
        end
    end

    assign stall = new_res && pend_valid_reg && !out_free;
    assign shift = (state_reg == ST_SCAN || state_reg == ST_APPLY) && !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_retry_reg  <= MAX_RETRY_RST;
            interval_reg   <= RETRY_INTERVAL_RST;
            m_found_reg    <= 1'b0;
            f_found_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_idx == REG_MAX_RETRY)
            begin
                max_retry_reg <= cfg_data[7:0];
            end
            if (cfg_we && cfg_idx == REG_RETRY_INTERVAL)
            begin
                interval_reg <= cfg_data;
            end
            if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        mode_reg    <= in_ch.mode;
                        id_reg      <= in_ch.msg_id;
                        addr_reg    <= in_ch.client_addr;
                        port_reg    <= in_ch.client_port;
                        now_reg     <= in_ch.now;
                        cnt_reg     <= '0;
                        n_reg       <= '0;
                        m_found_reg <= 1'b0;
                        f_found_reg <= 1'b0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (shift)
                    begin
                        cnt_reg     <= last_step ? '0 : cnt_reg + 1'b1;
                        m_found_reg <= m_found_c;
                        m_idx_reg   <= m_idx_c;
                        m_cnt_reg   <= m_cnt_c;
                        f_found_reg <= f_found_c;
                        f_idx_reg   <= f_idx_c;
                        if (new_res)
                        begin
                            if (pend_valid_reg)
                            begin
                                out_reg       <= pend_reg;
                                out_valid_reg <= 1'b1;
                            end
                            pend_reg       <= res;
                            pend_valid_reg <= 1'b1;
                            n_reg          <= n_reg + 5'd1;
                        end
                        if (last_step)
                        begin
                            state_reg <= ST_FLUSH;
                            if (mode_reg == MODE_POST || mode_reg == MODE_ACK)
                            begin
                                pend_valid_reg <= 1'b1;
                                pend_reg <= '{kind: KIND_NOACTION, msg_id: id_reg,
                                              addr: addr_reg, port: port_reg,
                                              count: 8'd0, last: 1'b0};
                                tgt_reg <= m_found_c ? m_idx_c : f_idx_c;
                                if (mode_reg == MODE_ACK && m_found_c)
                                begin
                                    pend_reg.kind  <= KIND_DELIVERED;
                                    pend_reg.count <= m_cnt_c;
                                    state_reg      <= ST_APPLY;
                                end
                                else if (mode_reg == MODE_POST)
                                begin
                                    if (m_found_c)
                                    begin
                                        pend_reg.kind  <= KIND_SEND;
                                        pend_reg.count <= sat_inc(m_cnt_c);
                                        state_reg      <= ST_APPLY;
                                    end
                                    else if (f_found_c)
                                    begin
                                        pend_reg.kind  <= KIND_SEND;
                                        pend_reg.count <= 8'd1;
                                        state_reg      <= ST_APPLY;
                                    end
                                    else
                                    begin
                                        pend_reg.kind <= KIND_FULL;
                                    end
                                end
                            end
                        end
                    end
                end
                ST_APPLY:
                begin
                    cnt_reg <= last_step ? '0 : cnt_reg + 1'b1;
                    if (last_step)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                end
                default:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_reg        <= pend_reg;
                        out_reg.last   <= 1'b1;
                        out_valid_reg  <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    assign in_ch.ready        = state_reg == ST_IDLE;
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = out_reg.kind;
    assign out_ch.out_msg_id  = out_reg.msg_id;
    assign out_ch.out_addr    = out_reg.addr;
    assign out_ch.out_port    = out_reg.port;
    assign out_ch.out_count   = out_reg.count;
    assign out_ch.last_result = out_reg.last;

    // A request starts with the hold stage empty and the ring at its home position.
    `ART_ASSERT(a_idle_clean, in_ch.ready |-> !pend_valid_reg && cnt_reg == '0, "dirty idle")
    `ART_ASSERT(a_limit, n_reg <= 5'(OUT_LIMIT), "result limit exceeded")
    `ART_ASSERT(a_no_stall_apply, state_reg == ST_APPLY |-> shift, "apply pass stalled")

endmodule
